[hdl/dts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the dependency sort block
// Field types, register map and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Graph size and field widths
    localparam int MAX_NODES = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;

    // Register map (index = byte address / 4)
    localparam int          PADDR_W        = 3;
    localparam logic        REG_NODE_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(32);

    // Input transfer
    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] dependency_index;
        logic             has_edge;
        logic             last_edge;
    } in_item_t;

    // Output transfer
    typedef struct packed {
        logic [IDX_W-1:0] ordered_node;
        logic             cycle_error;
        logic             last_result;
    } out_item_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_node;
        logic [IDX_W-1:0]     wr_dep;
        logic                 remove_en;
        logic                 clear;
        logic [MAX_NODES-1:0] active;
        logic [MAX_NODES-1:0] removed;
    } cell_ctrl_t;

endpackage

[hdl/dts_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_cell: one node of the sort chain
// Holds the node's dependency row and removed flag, decides readiness and
// passes the "already taken" token on to the next higher node.
// ----------------------------------------------------------------------------
module dts_cell
    import dts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  cell_ctrl_t       ctrl,
    input  logic             taken_in,
    output logic             taken_out,
    output logic             pick,
    output logic             removed
);

    logic [MAX_NODES-1:0] row_reg, row_next;
    logic                 removed_reg, removed_next;
    logic                 eligible;

    // Ready: active, not removed, every live dependency already removed
    assign eligible = ctrl.active[cell_index] && !removed_reg
                      && ((row_reg & ctrl.active & ~ctrl.removed) == '0);

    // Lowest ready node wins: lower cells pass the token up
    assign pick      = eligible && !taken_in;
    assign taken_out = taken_in || eligible;
    assign removed   = removed_reg;

    // Row and flag update
    always_comb
    begin
        row_next     = row_reg;
        removed_next = removed_reg;
        if (ctrl.clear)
        begin
            row_next     = '0;
            removed_next = 1'b0;
        end
        else
        begin
            if (ctrl.wr_en && (ctrl.wr_node == cell_index))
                row_next[ctrl.wr_dep] = 1'b1;
            if (ctrl.remove_en && pick)
                removed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            removed_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            removed_reg <= removed_next;
        end
    end

endmodule

[hdl/dependency_topological_sort_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_topological_sort_top: Kahn ordering over a row of node cells
// Loads dependency edges, then emits the nodes in dependency order.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle into a chain of 32 cells, one per node, each
// holding its dependency row. The transfer marked last_edge starts the sort;
// from then on the block emits one result per cycle while the output is
// taken (node_count, clamped to 1..32, or up to that many ending in a cycle
// error result), the lowest ready node found by a token rippling up the cell
// chain combinationally. No input is accepted during the sort. The matrix is
// cleared in the same cycle as the final result, so the next graph can be
// loaded immediately, even while that result still waits in the output
// register. Write node_count (register 0) only while idle; not enforced.
// ----------------------------------------------------------------------------
module dependency_topological_sort_top
    import dts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Edge input
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    // Ordered output
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SORT = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     node_count_reg;
    logic [CNT_W-1:0]     emitted_reg, emitted_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;
    logic [CNT_W-1:0]     eff_count;
    cell_ctrl_t           ctrl;
    logic [MAX_NODES:0]   taken;
    logic [MAX_NODES-1:0] pick_vec;
    logic [MAX_NODES-1:0] removed_vec;
    logic [IDX_W-1:0]     pick_idx;
    logic                 in_xfer;
    logic                 can_emit;
    logic                 found;
    logic                 final_node;

    // Register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NODE_COUNT_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT))
            node_count_reg <= pwdata[CNT_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NODE_COUNT)
            prdata = {{(32-CNT_W){1'b0}}, node_count_reg};
    end

    // Effective node count, clamped to 1..MAX_NODES
    always_comb
    begin
        priority if (node_count_reg == '0)
            eff_count = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            eff_count = CNT_W'(MAX_NODES);
        else
            eff_count = node_count_reg;
    end

    // Handshakes
    assign in_ready = (state_reg == ST_LOAD);
    assign in_xfer  = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;
    assign found    = taken[MAX_NODES];

    // Winner index from the one-hot pick vector
    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < MAX_NODES; i++)
            if (pick_vec[i])
                pick_idx = pick_idx | IDX_W'(i);
    end

    assign final_node = ((emitted_reg + CNT_W'(1)) == eff_count);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        ctrl.wr_en     = in_xfer && in_data.has_edge
                         && ({1'b0, in_data.node_index} < CNT_W'(MAX_NODES))
                         && ({1'b0, in_data.dependency_index} < CNT_W'(MAX_NODES));
        ctrl.wr_node   = in_data.node_index;
        ctrl.wr_dep    = in_data.dependency_index;
        ctrl.remove_en = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.removed   = removed_vec;
        for (int i = 0; i < MAX_NODES; i++)
            ctrl.active[i] = (CNT_W'(i) < eff_count);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && in_data.last_edge)
                    state_next = ST_SORT;
            end
            ST_SORT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (found)
                    begin
                        ctrl.remove_en             = 1'b1;
                        emitted_next               = emitted_reg + CNT_W'(1);
                        out_data_next.ordered_node = pick_idx;
                        out_data_next.cycle_error  = 1'b0;
                        out_data_next.last_result  = final_node;
                        if (final_node)
                        begin
                            ctrl.clear   = 1'b1;
                            emitted_next = '0;
                            state_next   = ST_LOAD;
                        end
                    end
                    else
                    begin
                        // No ready node: circular dependency
                        out_data_next.ordered_node = '0;
                        out_data_next.cycle_error  = 1'b1;
                        out_data_next.last_result  = 1'b1;
                        ctrl.clear                 = 1'b1;
                        emitted_next               = '0;
                        state_next                 = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Cell chain
    assign taken[0] = 1'b0;

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_cell
        dts_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(g)),
            .ctrl       (ctrl),
            .taken_in   (taken[g]),
            .taken_out  (taken[g+1]),
            .pick       (pick_vec[g]),
            .removed    (removed_vec[g])
        );
    end

endmodule

[hdl/dts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_checker: port-level checks for the dependency sort block
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module dts_checker
    import dts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Error result ends the run and carries node zero
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cycle_error |->
            out_data.last_result && (out_data.ordered_node == '0))
        else $error("malformed cycle error result");

    // Sorting blocks further edges
    a_sort_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_edge |=> !in_ready)
        else $error("input taken during sort");

    // No result is shown once reset has been seen at a clock edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind dependency_topological_sort_top dts_checker u_dts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
